/* rtl/core/tpfk_pkg.sv */
// ----------------------------------------------------------------------------
// tpfk_pkg
// Shared types and constants for the tree pose forward kinematics block.
// ----------------------------------------------------------------------------
package tpfk_pkg;

    localparam int MAX_NODES_DEF      = 256;
    localparam int QUAT_FRAC_BITS_DEF = 14;
    localparam int ROT_WIDTH          = 64;
    localparam int POS_WIDTH          = 96;

    localparam logic OPC_COMPOSE   = 1'b0;
    localparam logic OPC_DECOMPOSE = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [7:0]         node_index;
        logic               has_parent;
        logic [7:0]         parent_index;
        logic signed [15:0] in_qx;
        logic signed [15:0] in_qy;
        logic signed [15:0] in_qz;
        logic signed [15:0] in_qw;
        logic signed [31:0] in_px;
        logic signed [31:0] in_py;
        logic signed [31:0] in_pz;
    } node_item_t;

    typedef struct packed {
        logic [7:0]         out_node;
        logic signed [15:0] out_qx;
        logic signed [15:0] out_qy;
        logic signed [15:0] out_qz;
        logic signed [15:0] out_qw;
        logic signed [31:0] out_px;
        logic signed [31:0] out_py;
        logic signed [31:0] out_pz;
        logic               order_error;
    } pose_item_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_QMUL,
        OP_CROSS,
        OP_ROT,
        OP_FINISH
    } dp_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_QMUL,
        ST_CROSS,
        ST_ROT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic       capture;
        logic       rd;
        dp_op_t     op;
        logic [1:0] lane;
    } cmd_t;

    typedef struct packed {
        logic linked;
        logic out_full;
    } status_t;

endpackage

/* rtl/core/tree_pose_forward_kinematics.sv */
// ----------------------------------------------------------------------------
// tree_pose_forward_kinematics
// Quaternion forward kinematics over a breadth-first ordered node stream.
// ----------------------------------------------------------------------------
// Input channel node_valid/node_stall/node carries one tree node per item.
// Output channel pose_valid/pose_stall/pose returns one pose per node.
// An item is taken when valid is high and stall is low.
// Compose turns a parent-relative pose into a global one, decompose does the
// reverse; both keep the node's global pose in an internal store indexed by
// node, which the node's children read later.
// A linked node runs read, load, quaternion product, cross product, rotation
// and finish in order; a root or a bad-order node goes from load to finish.
// pose_valid is registered by the finish step. One item is in work at a time,
// so a new node is taken only once the last one has finished; the single
// four-multiplier unit runs four quaternion lanes, three cross lanes and
// three rotation lanes in turn, after one store read.
// The next item is accepted while the previous result waits in the output
// register; a result held by pose_stall blocks only the next finish step.
// Reset clears control state only; the pose store is not cleared, and a
// parent that was never written reads as whatever the store holds.
// ----------------------------------------------------------------------------
module tree_pose_forward_kinematics import tpfk_pkg::*; #(
    parameter int MAX_NODES      = MAX_NODES_DEF,
    parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       node_valid,
    output logic       node_stall,
    input  node_item_t node,
    output logic       pose_valid,
    input  logic       pose_stall,
    output pose_item_t pose
);

    cmd_t    cmd;
    status_t status;

    tpfk_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .node_valid(node_valid),
        .node_stall(node_stall),
        .cmd       (cmd),
        .status    (status)
    );

    tpfk_datapath #(
        .MAX_NODES     (MAX_NODES),
        .QUAT_FRAC_BITS(QUAT_FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .node      (node),
        .pose_valid(pose_valid),
        .pose_stall(pose_stall),
        .pose      (pose)
    );

endmodule

/* rtl/core/tpfk_ram.sv */
// ----------------------------------------------------------------------------
// tpfk_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tpfk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/tpfk_ctrl.sv */
// ----------------------------------------------------------------------------
// tpfk_ctrl
// Sequencer: parent read, quaternion product, cross products, rotation, store.
// ----------------------------------------------------------------------------
module tpfk_ctrl import tpfk_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    node_valid,
    output logic    node_stall,
    output cmd_t    cmd,
    input  status_t status
);

    state_t     state_reg, state_next;
    logic [1:0] lane_reg, lane_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            lane_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            lane_reg  <= lane_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        lane_next   = lane_reg;
        node_stall  = 1'b1;
        cmd.capture = 1'b0;
        cmd.rd      = 1'b0;
        cmd.op      = OP_NONE;
        cmd.lane    = lane_reg;
        case (state_reg)
            ST_IDLE:
            begin
                node_stall = 1'b0;
                if (node_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.op     = OP_LOAD;
                lane_next  = 2'd0;
                state_next = status.linked ? ST_QMUL : ST_FINISH;
            end
            ST_QMUL:
            begin
                cmd.op    = OP_QMUL;
                lane_next = lane_reg + 2'd1;
                if (lane_reg == 2'd3)
                begin
                    lane_next  = 2'd0;
                    state_next = ST_CROSS;
                end
            end
            ST_CROSS:
            begin
                cmd.op    = OP_CROSS;
                lane_next = lane_reg + 2'd1;
                if (lane_reg == 2'd2)
                begin
                    lane_next  = 2'd0;
                    state_next = ST_ROT;
                end
            end
            ST_ROT:
            begin
                cmd.op    = OP_ROT;
                lane_next = lane_reg + 2'd1;
                if (lane_reg == 2'd2)
                begin
                    lane_next  = 2'd0;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!status.out_full)
                begin
                    cmd.op     = OP_FINISH;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/tpfk_datapath.sv */
// ----------------------------------------------------------------------------
// tpfk_datapath
// Pose store, operand registers and a four-multiplier arithmetic unit.
// ----------------------------------------------------------------------------
module tpfk_datapath import tpfk_pkg::*; #(
    parameter int MAX_NODES      = MAX_NODES_DEF,
    parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    output status_t    status,
    input  node_item_t node,
    output logic       pose_valid,
    input  logic       pose_stall,
    output pose_item_t pose
);

    localparam int AW = $clog2(MAX_NODES);
    localparam int XW = (AW > 8) ? AW : 8;
    localparam int F  = QUAT_FRAC_BITS;
    localparam int TW = 52 - F;
    localparam int BW = (TW > 34) ? TW : 34;
    localparam int PW = 17 + BW;
    localparam int SW = PW + 3;
    localparam int MW = ROT_WIDTH + POS_WIDTH;
    localparam logic signed [SW-1:0] HALF  = SW'(1) <<< (F - 1);
    localparam logic signed [SW-1:0] Q_MAX = SW'(32767);
    localparam logic signed [SW-1:0] Q_MIN = -SW'(32768);
    localparam logic signed [SW-1:0] P_MAX = SW'(64'sd2147483647);
    localparam logic signed [SW-1:0] P_MIN = -SW'(64'sd2147483648);

    function automatic logic signed [SW-1:0] rnd(input logic signed [SW-1:0] x);
        return (x + HALF) >>> F;
    endfunction

    node_item_t         in_reg;
    pose_item_t         pose_reg;
    logic               pose_valid_reg;
    logic signed [16:0] pq_reg [4];
    logic signed [32:0] v_reg [3];
    logic signed [31:0] base_reg [3];
    logic signed [15:0] rq_reg [4];
    logic signed [TW-1:0] t_reg [3];
    logic signed [31:0] rp_reg [3];

    logic               err, linked, par_ok, node_ok;
    logic [XW-1:0]      par_ext, node_ext;
    logic [MW-1:0]      rdata, wdata;
    logic               we;
    logic signed [15:0] in_q [4];
    logic signed [31:0] in_p [3];
    logic signed [15:0] fin_q [4];
    logic signed [31:0] fin_p [3];

    logic signed [16:0]   ma [4];
    logic signed [BW-1:0] mb [4];
    logic                 neg [4];
    logic signed [PW-1:0] prod [4];
    logic signed [SW-1:0] term [4];
    logic signed [SW-1:0] sum_all, sum_ut, rsum;
    logic [1:0]           n1, n2;

    assign err     = in_reg.has_parent && (in_reg.parent_index >= in_reg.node_index);
    assign linked  = in_reg.has_parent && !err;
    assign par_ext = XW'(in_reg.parent_index);
    assign node_ext = XW'(in_reg.node_index);
    assign par_ok  = {1'b0, par_ext} < (XW + 1)'(MAX_NODES);
    assign node_ok = {1'b0, node_ext} < (XW + 1)'(MAX_NODES);

    assign in_q[0] = in_reg.in_qx;
    assign in_q[1] = in_reg.in_qy;
    assign in_q[2] = in_reg.in_qz;
    assign in_q[3] = in_reg.in_qw;
    assign in_p[0] = in_reg.in_px;
    assign in_p[1] = in_reg.in_py;
    assign in_p[2] = in_reg.in_pz;

    assign status.linked   = linked;
    assign status.out_full = pose_valid_reg && pose_stall;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            fin_q[k] = linked ? rq_reg[k] : in_q[k];
        end
        for (int k = 0; k < 3; k++)
        begin
            fin_p[k] = linked ? rp_reg[k] : in_p[k];
        end
        if (in_reg.opcode == OPC_COMPOSE)
        begin
            wdata = {fin_p[2], fin_p[1], fin_p[0], fin_q[3], fin_q[2], fin_q[1], fin_q[0]};
        end
        else
        begin
            wdata = {in_p[2], in_p[1], in_p[0], in_q[3], in_q[2], in_q[1], in_q[0]};
        end
    end

    assign we = (cmd.op == OP_FINISH) && node_ok;

    tpfk_ram #(
        .WIDTH(MW),
        .DEPTH(MAX_NODES)
    ) u_store (
        .clk  (clk),
        .we   (we),
        .waddr(node_ext[AW-1:0]),
        .wdata(wdata),
        .re   (cmd.rd),
        .raddr(par_ext[AW-1:0]),
        .rdata(rdata)
    );

    // lane indices for cross products and rotation
    always_comb
    begin
        case (cmd.lane)
            2'd0:
            begin
                n1 = 2'd1;
                n2 = 2'd2;
            end
            2'd1:
            begin
                n1 = 2'd2;
                n2 = 2'd0;
            end
            2'd2:
            begin
                n1 = 2'd0;
                n2 = 2'd1;
            end
            default:
            begin
                n1 = 2'd1;
                n2 = 2'd2;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            ma[i]  = '0;
            mb[i]  = '0;
            neg[i] = 1'b0;
        end
        case (cmd.op)
            OP_QMUL:
            begin
                ma[0] = pq_reg[3];
                ma[1] = pq_reg[0];
                ma[2] = pq_reg[1];
                ma[3] = pq_reg[2];
                case (cmd.lane)
                    2'd0:
                    begin
                        mb[0] = BW'(in_q[0]); mb[1] = BW'(in_q[3]);
                        mb[2] = BW'(in_q[2]); mb[3] = BW'(in_q[1]);
                        neg[3] = 1'b1;
                    end
                    2'd1:
                    begin
                        mb[0] = BW'(in_q[1]); mb[1] = BW'(in_q[2]);
                        mb[2] = BW'(in_q[3]); mb[3] = BW'(in_q[0]);
                        neg[1] = 1'b1;
                    end
                    2'd2:
                    begin
                        mb[0] = BW'(in_q[2]); mb[1] = BW'(in_q[1]);
                        mb[2] = BW'(in_q[0]); mb[3] = BW'(in_q[3]);
                        neg[2] = 1'b1;
                    end
                    default:
                    begin
                        mb[0] = BW'(in_q[3]); mb[1] = BW'(in_q[0]);
                        mb[2] = BW'(in_q[1]); mb[3] = BW'(in_q[2]);
                        neg[1] = 1'b1;
                        neg[2] = 1'b1;
                        neg[3] = 1'b1;
                    end
                endcase
            end
            OP_CROSS:
            begin
                ma[0]  = pq_reg[n1];
                mb[0]  = BW'(v_reg[n2]);
                ma[1]  = pq_reg[n2];
                mb[1]  = BW'(v_reg[n1]);
                neg[1] = 1'b1;
            end
            OP_ROT:
            begin
                ma[0]  = pq_reg[3];
                mb[0]  = BW'(t_reg[cmd.lane]);
                ma[1]  = pq_reg[n1];
                mb[1]  = BW'(t_reg[n2]);
                ma[2]  = pq_reg[n2];
                mb[2]  = BW'(t_reg[n1]);
                neg[2] = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            prod[i] = ma[i] * mb[i];
            term[i] = neg[i] ? -SW'(prod[i]) : SW'(prod[i]);
        end
        sum_all = term[0] + term[1] + term[2] + term[3];
        sum_ut  = term[1] + term[2];
        rsum    = SW'(base_reg[cmd.lane]) + SW'(v_reg[cmd.lane])
                + rnd(term[0]) + rnd(sum_ut);
    end

    logic signed [SW-1:0] qr;
    assign qr = rnd(sum_all);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_reg <= node;
        end
        case (cmd.op)
            OP_LOAD:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    if (!par_ok)
                    begin
                        pq_reg[k] <= '0;
                    end
                    else if (in_reg.opcode == OPC_DECOMPOSE && k < 3)
                    begin
                        pq_reg[k] <= -17'(signed'(rdata[16*k +: 16]));
                    end
                    else
                    begin
                        pq_reg[k] <= 17'(signed'(rdata[16*k +: 16]));
                    end
                end
                for (int k = 0; k < 3; k++)
                begin
                    if (in_reg.opcode == OPC_DECOMPOSE)
                    begin
                        base_reg[k] <= '0;
                        v_reg[k]    <= 33'(in_p[k])
                                     - (par_ok ? 33'(signed'(rdata[ROT_WIDTH + 32*k +: 32]))
                                               : 33'sd0);
                    end
                    else
                    begin
                        base_reg[k] <= par_ok ? signed'(rdata[ROT_WIDTH + 32*k +: 32]) : '0;
                        v_reg[k]    <= 33'(in_p[k]);
                    end
                end
            end
            OP_QMUL:
            begin
                if (qr > Q_MAX)
                begin
                    rq_reg[cmd.lane] <= 16'sh7fff;
                end
                else if (qr < Q_MIN)
                begin
                    rq_reg[cmd.lane] <= 16'sh8000;
                end
                else
                begin
                    rq_reg[cmd.lane] <= qr[15:0];
                end
            end
            OP_CROSS:
            begin
                t_reg[cmd.lane] <= TW'(rnd(sum_all <<< 1));
            end
            OP_ROT:
            begin
                if (rsum > P_MAX)
                begin
                    rp_reg[cmd.lane] <= 32'sh7fffffff;
                end
                else if (rsum < P_MIN)
                begin
                    rp_reg[cmd.lane] <= 32'sh80000000;
                end
                else
                begin
                    rp_reg[cmd.lane] <= rsum[31:0];
                end
            end
            OP_FINISH:
            begin
                pose_reg.out_node    <= in_reg.node_index;
                pose_reg.out_qx      <= fin_q[0];
                pose_reg.out_qy      <= fin_q[1];
                pose_reg.out_qz      <= fin_q[2];
                pose_reg.out_qw      <= fin_q[3];
                pose_reg.out_px      <= fin_p[0];
                pose_reg.out_py      <= fin_p[1];
                pose_reg.out_pz      <= fin_p[2];
                pose_reg.order_error <= err;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose_valid_reg <= 1'b0;
        end
        else if (cmd.op == OP_FINISH)
        begin
            pose_valid_reg <= 1'b1;
        end
        else if (!pose_stall)
        begin
            pose_valid_reg <= 1'b0;
        end
    end

    assign pose_valid = pose_valid_reg;
    assign pose       = pose_reg;

endmodule
